### design/mlrt_pkg.sv
// Shared types and constants for the machine load rank table.
package mlrt_pkg;

    localparam int MAX_MACHINES = 16;
    localparam int MAX_JOBS     = 256;
    localparam int LOAD_BITS    = 32;
    localparam int DUR_W        = 16;
    localparam int MACH_IDX_W   = $clog2(MAX_MACHINES);
    localparam int MACH_NUM_W   = $clog2(MAX_MACHINES + 1);
    localparam int JOB_IDX_W    = $clog2(MAX_JOBS);
    localparam int JOB_CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int RANK_W       = 4;
    localparam int OUT_LOAD_W   = 32;

    typedef enum logic [1:0] {
        ACT_SET_DUR = 2'd0,
        ACT_ASSIGN  = 2'd1,
        ACT_FLUSH   = 2'd2,
        ACT_QUERY   = 2'd3
    } action_t;

    typedef struct packed {
        logic                  flush;
        logic                  add;
        logic [MACH_IDX_W-1:0] add_idx;
        logic [DUR_W-1:0]      add_val;
        logic                  load_ring;
        logic                  step;
        logic                  desc;
        logic [MACH_NUM_W-1:0] nm;
    } cell_ctrl_t;

    typedef struct packed {
        logic                  read;
        logic                  wr_dur;
        logic                  assign_en;
        logic                  flush;
        logic                  scan;
        logic [JOB_IDX_W-1:0]  job;
        logic [MACH_NUM_W-1:0] mach;
        logic [DUR_W-1:0]      dur;
        logic [MACH_NUM_W-1:0] nm;
        logic [JOB_CNT_W-1:0]  nj;
    } job_ctrl_t;

    typedef struct packed {
        logic [DUR_W-1:0]     dur;
        logic [JOB_CNT_W-1:0] good_count;
        logic                 busy;
    } job_stat_t;

endpackage

### design/mlrt_cell.sv
// One machine cell: holds a load and counts machines that rank ahead of it.
module mlrt_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [mlrt_pkg::MACH_IDX_W-1:0]      my_idx,
    input  mlrt_pkg::cell_ctrl_t                 ctrl,
    input  logic [mlrt_pkg::LOAD_BITS-1:0]       ring_load_in,
    input  logic [mlrt_pkg::MACH_IDX_W-1:0]      ring_idx_in,
    output logic [mlrt_pkg::LOAD_BITS-1:0]       ring_load_out,
    output logic [mlrt_pkg::MACH_IDX_W-1:0]      ring_idx_out,
    output logic [mlrt_pkg::RANK_W-1:0]          pos
);
    import mlrt_pkg::*;

    logic [LOAD_BITS-1:0]  load_reg;
    logic [LOAD_BITS-1:0]  ring_load_reg;
    logic [MACH_IDX_W-1:0] ring_idx_reg;
    logic [RANK_W-1:0]     pos_reg;
    logic [LOAD_BITS:0]    sum;
    logic [LOAD_BITS-1:0]  load_next;
    logic                  ahead;

    assign sum = {1'b0, load_reg} + (LOAD_BITS + 1)'(ctrl.add_val);
    assign load_next = sum[LOAD_BITS] ? {LOAD_BITS{1'b1}} : sum[LOAD_BITS-1:0];

    always_comb
    begin
        if (ring_load_reg != load_reg)
            ahead = ctrl.desc ? (ring_load_reg > load_reg) : (ring_load_reg < load_reg);
        else
            ahead = ring_idx_reg < my_idx;
        if (MACH_NUM_W'(ring_idx_reg) >= ctrl.nm || ring_idx_reg == my_idx)
            ahead = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
        end
        else if (ctrl.flush)
        begin
            load_reg <= '0;
        end
        else if (ctrl.add && ctrl.add_idx == my_idx)
        begin
            load_reg <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_ring)
        begin
            ring_load_reg <= load_reg;
            ring_idx_reg  <= my_idx;
            pos_reg       <= '0;
        end
        else if (ctrl.step)
        begin
            ring_load_reg <= ring_load_in;
            ring_idx_reg  <= ring_idx_in;
            pos_reg       <= pos_reg + RANK_W'(ahead);
        end
    end

    assign ring_load_out = ring_load_reg;
    assign ring_idx_out  = ring_idx_reg;
    assign pos           = pos_reg;

endmodule

### design/mlrt_jobs.sv
// Job side: duration memory, owner memory and count of properly owned jobs.
module mlrt_jobs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mlrt_pkg::job_ctrl_t  ctrl,
    output mlrt_pkg::job_stat_t  stat
);
    import mlrt_pkg::*;

    logic [DUR_W-1:0]      dur_mem [MAX_JOBS];
    logic [MACH_NUM_W-1:0] own_mem [MAX_JOBS];
    logic [MAX_JOBS-1:0]   own_valid_reg;
    logic [DUR_W-1:0]      dur_q_reg;
    logic [MACH_NUM_W-1:0] own_q_reg;
    logic                  own_v_q_reg;
    logic                  issue_reg;
    logic                  rdv_reg;
    logic [JOB_CNT_W-1:0]  scan_addr_reg;
    logic [JOB_CNT_W-1:0]  count_reg;
    logic                  scan_rd;
    logic                  own_rd_en;
    logic [JOB_IDX_W-1:0]  own_rd_addr;
    logic                  good_q;

    assign scan_rd     = issue_reg && (scan_addr_reg < ctrl.nj);
    assign own_rd_en   = ctrl.read || scan_rd;
    assign own_rd_addr = issue_reg ? scan_addr_reg[JOB_IDX_W-1:0] : ctrl.job;
    assign good_q      = own_v_q_reg && (own_q_reg != '0) && (own_q_reg <= ctrl.nm);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_dur)
            dur_mem[ctrl.job] <= ctrl.dur;
        if (ctrl.read)
            dur_q_reg <= dur_mem[ctrl.job];
        if (ctrl.assign_en)
            own_mem[ctrl.job] <= ctrl.mach;
        if (own_rd_en)
            own_q_reg <= own_mem[own_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_valid_reg <= '0;
            own_v_q_reg   <= 1'b0;
        end
        else
        begin
            if (own_rd_en)
                own_v_q_reg <= own_valid_reg[own_rd_addr];
            if (ctrl.flush)
                own_valid_reg <= '0;
            else if (ctrl.assign_en)
                own_valid_reg[ctrl.job] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg     <= 1'b0;
            rdv_reg       <= 1'b0;
            scan_addr_reg <= '0;
            count_reg     <= '0;
        end
        else if (ctrl.scan)
        begin
            issue_reg     <= 1'b1;
            rdv_reg       <= 1'b0;
            scan_addr_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            rdv_reg <= scan_rd;
            if (issue_reg)
            begin
                if (scan_rd)
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                else
                    issue_reg <= 1'b0;
            end
            if (ctrl.flush)
                count_reg <= '0;
            else if (ctrl.assign_en && !good_q)
                count_reg <= count_reg + 1'b1;
            else if (rdv_reg && good_q)
                count_reg <= count_reg + 1'b1;
        end
    end

    assign stat.dur        = dur_q_reg;
    assign stat.good_count = count_reg;
    assign stat.busy       = issue_reg || rdv_reg;

endmodule

### design/machine_load_rank_table.sv
// Top level of the machine load rank table.
//
// Usage:
//   Input stream s_axis_*: one transaction per command (set duration,
//   assign, flush, query). s_axis_tuser carries the action code.
//   Output stream m_axis_*: exactly one result transaction per command.
//   APB port: register 0 machine_count at 0x0, register 1 job_count at 0x4.
// Timing:
//   A command runs from accept to result through one memory read,
//   one update, and a 16-step rotation of machine loads around the cell
//   ring that yields the minimum and the rank of every machine.
//   The first command after a register write first rescans the owner
//   memory, one job per cycle.
//   One command is in flight at a time; s_axis_tready is high when idle.
// Reset:
//   Loads, owners and counts clear at once; registers read back as 1.
//   A stalled result holds in the output register until m_axis_tready.
module machine_load_rank_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] job_index, [12:8] target_machine, [28:13] job_duration,
    // [32:29] rank_wanted, [33] longest_first, rest zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] ranked_machine, [36:5] lowest_load, [37] all_assigned,
    // [38] error_flag, rest zero
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mlrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_APPLY,
        ST_RING,
        ST_STEP,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [MACH_NUM_W-1:0] mc_reg;
    logic [JOB_CNT_W-1:0]  jc_reg;
    logic                  dirty_reg;
    action_t               act_reg;
    logic [JOB_IDX_W-1:0]  job_reg;
    logic [MACH_NUM_W-1:0] mach_reg;
    logic [DUR_W-1:0]      dur_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic                  desc_reg;
    logic                  err_reg;
    logic [MACH_IDX_W-1:0] step_reg;
    logic [LOAD_BITS-1:0]  min_reg;
    logic                  out_valid_reg;
    logic [39:0]           out_data_reg;

    logic [MACH_NUM_W-1:0] nm;
    logic [JOB_CNT_W-1:0]  nj;
    logic                  in_fire;
    logic                  cfg_wr;
    logic                  out_free;
    logic                  err_now;
    logic                  job_bad;
    logic                  mach_bad;
    cell_ctrl_t            cctrl;
    job_ctrl_t             jctrl;
    job_stat_t             jstat;
    logic [LOAD_BITS-1:0]  ring_load [MAX_MACHINES];
    logic [MACH_IDX_W-1:0] ring_idx  [MAX_MACHINES];
    logic [RANK_W-1:0]     pos       [MAX_MACHINES];
    logic [MACH_IDX_W-1:0] hit_idx;
    logic [MACH_NUM_W-1:0] ranked;
    logic [OUT_LOAD_W-1:0] low_out;

    assign nm = (mc_reg == '0) ? MACH_NUM_W'(1) :
                (mc_reg > MACH_NUM_W'(MAX_MACHINES)) ? MACH_NUM_W'(MAX_MACHINES) : mc_reg;
    assign nj = (jc_reg == '0) ? JOB_CNT_W'(1) :
                (jc_reg > JOB_CNT_W'(MAX_JOBS)) ? JOB_CNT_W'(MAX_JOBS) : jc_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? 32'(jc_reg) : 32'(mc_reg);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign job_bad  = JOB_CNT_W'(job_reg) >= nj;
    assign mach_bad = (mach_reg == '0) || (mach_reg > nm);

    always_comb
    begin
        case (act_reg)
            ACT_SET_DUR: err_now = job_bad;
            ACT_ASSIGN:  err_now = job_bad || mach_bad;
            ACT_QUERY:   err_now = MACH_NUM_W'(rank_reg) >= nm;
            default:     err_now = 1'b0;
        endcase
    end

    always_comb
    begin
        cctrl           = '0;
        cctrl.add_idx   = MACH_IDX_W'(mach_reg - 1'b1);
        cctrl.add_val   = jstat.dur;
        cctrl.desc      = desc_reg;
        cctrl.nm        = nm;
        cctrl.load_ring = (state_reg == ST_RING);
        cctrl.step      = (state_reg == ST_STEP);
        jctrl           = '0;
        jctrl.job       = job_reg;
        jctrl.mach      = mach_reg;
        jctrl.dur       = dur_reg;
        jctrl.nm        = nm;
        jctrl.nj        = nj;
        jctrl.scan      = in_fire && dirty_reg;
        jctrl.read      = (state_reg == ST_READ);
        if (state_reg == ST_APPLY && !err_now)
        begin
            case (act_reg)
                ACT_SET_DUR: jctrl.wr_dur = 1'b1;
                ACT_ASSIGN:
                begin
                    jctrl.assign_en = 1'b1;
                    cctrl.add       = 1'b1;
                end
                ACT_FLUSH:
                begin
                    jctrl.flush = 1'b1;
                    cctrl.flush = 1'b1;
                end
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < MAX_MACHINES; g++)
    begin : g_cell
        mlrt_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .my_idx        (MACH_IDX_W'(g)),
            .ctrl          (cctrl),
            .ring_load_in  (ring_load[(g + MAX_MACHINES - 1) % MAX_MACHINES]),
            .ring_idx_in   (ring_idx[(g + MAX_MACHINES - 1) % MAX_MACHINES]),
            .ring_load_out (ring_load[g]),
            .ring_idx_out  (ring_idx[g]),
            .pos           (pos[g])
        );
    end

    mlrt_jobs u_jobs (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (jctrl),
        .stat  (jstat)
    );

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX_MACHINES; i++)
        begin
            if (MACH_NUM_W'(i) < nm && pos[i] == rank_reg)
                hit_idx = MACH_IDX_W'(i);
        end
    end

    assign ranked  = (act_reg == ACT_QUERY && !err_reg) ?
                     (MACH_NUM_W'(hit_idx) + 1'b1) : '0;
    assign low_out = OUT_LOAD_W'(min_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mc_reg        <= MACH_NUM_W'(1);
            jc_reg        <= JOB_CNT_W'(1);
            dirty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                dirty_reg <= 1'b1;
                if (paddr[2])
                    jc_reg <= pwdata[JOB_CNT_W-1:0];
                else
                    mc_reg <= pwdata[MACH_NUM_W-1:0];
            end
            else if (jctrl.scan)
            begin
                dirty_reg <= 1'b0;
            end
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                        state_reg <= dirty_reg ? ST_SCAN : ST_READ;
                end
                ST_SCAN:
                begin
                    if (!jstat.busy)
                        state_reg <= ST_READ;
                end
                ST_READ:  state_reg <= ST_APPLY;
                ST_APPLY: state_reg <= ST_RING;
                ST_RING:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == MACH_IDX_W'(MAX_MACHINES - 1))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= action_t'(s_axis_tuser);
            job_reg  <= s_axis_tdata[7:0];
            mach_reg <= s_axis_tdata[12:8];
            dur_reg  <= s_axis_tdata[28:13];
            rank_reg <= s_axis_tdata[32:29];
            desc_reg <= s_axis_tdata[33];
        end
        if (state_reg == ST_APPLY)
            err_reg <= err_now;
        if (state_reg == ST_RING)
            min_reg <= {LOAD_BITS{1'b1}};
        else if (state_reg == ST_STEP && MACH_NUM_W'(ring_idx[0]) < nm
                 && ring_load[0] < min_reg)
            min_reg <= ring_load[0];
        if (state_reg == ST_DONE && out_free)
            out_data_reg <= {1'b0, err_reg, (jstat.good_count == nj), low_out, ranked};
    end

endmodule
